// ===== sv/assert_macros.svh =====
// Assertion macros for the decoder top level.
// Uses clk_i and rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define URLPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define URLPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/urlpd_pkg.sv =====
// Shared types, character constants and hex helpers for the URL percent decoder.
// No dependencies.
`timescale 1ns / 1ps

package urlpd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] DigitTen  = 8'd10;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhPct  = 2'd1,
    PhDig  = 2'd2
  } phase_e;

  // One decoded run: up to three output bytes produced by one input word.
  typedef struct packed {
    logic [1:0]                  cnt;
    logic                        term;
    logic [MaxResults-1:0][7:0]  bytes;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = ((c >= CharZero) && (c <= CharNine)) ||
             ((c >= CharLowA) && (c <= CharLowF)) ||
             ((c >= CharUpA)  && (c <= CharUpF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] v;
    u = (c >= CharLowA) ? (c - (CharLowA - CharUpA)) : c;
    v = (u >= CharUpA) ? (u - (CharUpA - DigitTen)) : (u - CharZero);
    hex_val = v[3:0];
  endfunction

endpackage

// ===== sv/url_percent_decoder.sv =====
// URL percent decoder top level: front end, run queue, back end.
// Depends on urlpd_pkg, urlpd_front, urlpd_queue, urlpd_back and assert_macros.svh.
//
// Input channel: in_valid_i / in_stall_o carry one encoded character per word
// (in_byte_i); a zero character ends the string. Output channel: out_valid_o /
// out_stall_i carry one decoded byte per word, with last_of_run_o on the final
// byte caused by an input word and string_end_o on the terminating zero.
// A "%hh" escape yields one byte on its second digit; a broken escape replays the
// percent sign (and held digit), then the breaking character if not a percent.
// The first byte of a run is registered in the run queue, which stores the accepted
// input word, and then in the output register, which the back end loads from it.
// One input word per cycle while each word makes at most one byte and the receiver
// does not stall; the back end drains one byte per cycle while not stalled. The run
// queue holds QueueDepth runs and the input stalls only while it is full.
// Reset clears the escape phase, the run queue and the output valid flag.
// While the receiver stalls, the output word holds, the queue fills and then
// in_stall_o rises.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module url_percent_decoder #(
  parameter int unsigned QueueDepth = urlpd_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       string_end_o
);

  urlpd_pkg::job_t job;
  urlpd_pkg::job_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_nonempty;
  logic            end_ok;
  logic            idle_in_reset;

  urlpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (job)
  );

  urlpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job),
    .pop_i      (pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .head_o     (head)
  );

  urlpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_nonempty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .string_end_o  (string_end_o)
  );

  assign end_ok = ~string_end_o | (last_of_run_o & (out_byte_o == urlpd_pkg::CharNul));
  // Flops may still be unknown at the first edge of reset
  assign idle_in_reset = (out_valid_o !== 1'b1) && (q_nonempty !== 1'b1);

  `URLPD_ASSERT(a_no_push_full, push |-> !q_full, "run pushed into full queue")
  `URLPD_ASSERT(a_no_pop_empty, pop |-> q_nonempty, "run popped from empty queue")
  `URLPD_ASSERT(a_end_is_last, out_valid_o |-> end_ok, "terminator not a zero closing its run")
  `URLPD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> idle_in_reset, "output or queue busy in reset")

endmodule

// ===== sv/urlpd_front.sv =====
// Front end: accepts input words, tracks the escape phase, builds result runs.
// Depends on urlpd_pkg.
`timescale 1ns / 1ps

module urlpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output urlpd_pkg::job_t   job_o
);

  urlpd_pkg::phase_e phase_q, phase_d;
  logic [7:0]        held_q, held_d;
  logic              accept;
  logic              c_hex;
  logic              c_pct;
  logic              c_nul;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign c_hex      = urlpd_pkg::is_hex(in_byte_i);
  assign c_pct      = (in_byte_i == urlpd_pkg::CharPct);
  assign c_nul      = (in_byte_i == urlpd_pkg::CharNul);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (accept) begin
      unique case (phase_q)
        urlpd_pkg::PhPct: begin
          if (c_hex) begin
            phase_d = urlpd_pkg::PhDig;
            held_d  = in_byte_i;
          end else begin
            phase_d = c_pct ? urlpd_pkg::PhPct : urlpd_pkg::PhIdle;
          end
        end
        urlpd_pkg::PhDig: begin
          if (c_hex) begin
            phase_d = urlpd_pkg::PhIdle;
          end else begin
            phase_d = c_pct ? urlpd_pkg::PhPct : urlpd_pkg::PhIdle;
          end
        end
        default: begin
          phase_d = c_pct ? urlpd_pkg::PhPct : urlpd_pkg::PhIdle;
        end
      endcase
    end
  end

  // Result run for the current word
  always_comb begin
    job_o = '0;
    unique case (phase_q)
      urlpd_pkg::PhPct: begin
        if (!c_hex) begin
          job_o.bytes[0] = urlpd_pkg::CharPct;
          if (c_pct) begin
            job_o.cnt = 2'd1;
          end else begin
            job_o.bytes[1] = in_byte_i;
            job_o.cnt      = 2'd2;
            job_o.term     = c_nul;
          end
        end
      end
      urlpd_pkg::PhDig: begin
        if (c_hex) begin
          job_o.bytes[0] = {urlpd_pkg::hex_val(held_q), urlpd_pkg::hex_val(in_byte_i)};
          job_o.cnt      = 2'd1;
        end else begin
          job_o.bytes[0] = urlpd_pkg::CharPct;
          job_o.bytes[1] = held_q;
          if (c_pct) begin
            job_o.cnt = 2'd2;
          end else begin
            job_o.bytes[2] = in_byte_i;
            job_o.cnt      = 2'd3;
            job_o.term     = c_nul;
          end
        end
      end
      default: begin
        if (!c_pct) begin
          job_o.bytes[0] = in_byte_i;
          job_o.cnt      = 2'd1;
          job_o.term     = c_nul;
        end
      end
    endcase
  end

  // Drop runs with no result
  assign push_o = accept & (job_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= urlpd_pkg::PhIdle;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== sv/urlpd_queue.sv =====
// Short queue of result runs between front end and back end.
// Depends on urlpd_pkg.
`timescale 1ns / 1ps

module urlpd_queue #(
  parameter int unsigned Depth = urlpd_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  urlpd_pkg::job_t   job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              nonempty_o,
  output urlpd_pkg::job_t   head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  urlpd_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o     = (count_q == CntFull);
  assign nonempty_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/urlpd_back.sv =====
// Back end: walks the head run one byte per cycle, unless stalled, into the output register.
// Depends on urlpd_pkg.
`timescale 1ns / 1ps

module urlpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  urlpd_pkg::job_t   head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o,
  output logic              string_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       end_q;
  logic       load;
  logic       is_last;

  assign load    = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign is_last = (idx_q == (head_i.cnt - 2'd1));
  assign pop_o   = load & is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      last_q <= is_last;
      end_q  <= is_last & head_i.term;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign string_end_o  = end_q;

endmodule

// ===== bench/url_percent_decoder_checker.sv =====
// Watches both channels of url_percent_decoder, predicts decoded words and compares them.
// Depends on urlpd_pkg for the character constants and the escape phase enum.
`timescale 1ns / 1ps

module url_percent_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_of_run_i,
  input  logic        string_end_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       term;
  } decoded_t;

  decoded_t          decoded_q[$];
  decoded_t          run_q[$];
  decoded_t          got_word;
  urlpd_pkg::phase_e esc_phase = urlpd_pkg::PhIdle;
  logic [7:0]        held_digit = '0;
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic is_hex_char(input logic [7:0] c);
    return ((c >= urlpd_pkg::CharZero) && (c <= urlpd_pkg::CharNine)) ||
           ((c >= urlpd_pkg::CharUpA) && (c <= urlpd_pkg::CharUpF)) ||
           ((c >= urlpd_pkg::CharLowA) && (c <= urlpd_pkg::CharLowF));
  endfunction

  // Letters of both cases have the digit value in the low nibble plus nine.
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c <= urlpd_pkg::CharNine) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic term);
    decoded_t w;
    w.data = b;
    w.last = 1'b0;
    w.term = term;
    run_q.push_back(w);
  endfunction

  function automatic void take_fresh(input logic [7:0] c);
    if (c == urlpd_pkg::CharPct) begin
      esc_phase = urlpd_pkg::PhPct;
    end else begin
      esc_phase = urlpd_pkg::PhIdle;
      emit(c, c == urlpd_pkg::CharNul);
    end
  endfunction

  function automatic void decode_word(input logic [7:0] c);
    decoded_t tail;
    run_q.delete();
    case (esc_phase)
      urlpd_pkg::PhPct: begin
        if (is_hex_char(c)) begin
          held_digit = c;
          esc_phase  = urlpd_pkg::PhDig;
        end else begin
          emit(urlpd_pkg::CharPct, 1'b0);
          take_fresh(c);
        end
      end
      urlpd_pkg::PhDig: begin
        if (is_hex_char(c)) begin
          emit({digit_value(held_digit), digit_value(c)}, 1'b0);
          esc_phase = urlpd_pkg::PhIdle;
        end else begin
          // replay the percent sign and the held digit, then the breaking character
          emit(urlpd_pkg::CharPct, 1'b0);
          emit(held_digit, 1'b0);
          take_fresh(c);
        end
      end
      default: take_fresh(c);
    endcase
    if (run_q.size() != 0) begin
      tail = run_q.pop_back();
      tail.last = 1'b1;
      run_q.push_back(tail);
    end
    foreach (run_q[i]) decoded_q.push_back(run_q[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_phase  = urlpd_pkg::PhIdle;
      held_digit = '0;
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_word(in_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("word with nothing pending, byte %02h", out_byte_i));
        end else begin
          got_word = decoded_q.pop_front();
          if (out_byte_i !== got_word.data) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_i, got_word.data));
          end
          if (last_of_run_i !== got_word.last) begin
            report_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
                                      last_of_run_i, got_word.last, got_word.data));
          end
          if (string_end_i !== got_word.term) begin
            report_mismatch($sformatf("string_end %b, want %b on byte %02h",
                                      string_end_i, got_word.term, got_word.data));
          end
        end
      end
      pending_o <= unsigned'(decoded_q.size());
    end
  end

endmodule

// ===== bench/url_percent_decoder_tb.sv =====
// Testbench top for url_percent_decoder: clock, reset, encoded strings and receiver stalls.
// Depends on urlpd_pkg, the decoder RTL and url_percent_decoder_checker.
`timescale 1ns / 1ps

module url_percent_decoder_tb;

  localparam int unsigned DirectedWords = 25;
  localparam int unsigned RandomWords   = 300;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned CycleLimit    = 400000;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = '0;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire  [7:0] out_byte;
  wire        last_of_run;
  wire        string_end;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count;
  int unsigned words_sent   = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  int unsigned rx_hold      = 0;
  int unsigned rx_mode_left = 0;

  // plain bytes, escapes of both cases, broken escapes and reprocessed characters
  logic [7:0] directed_seq [DirectedWords] = '{
    urlpd_pkg::CharNul, "A", 8'hFF, "+",
    urlpd_pkg::CharPct, "4", "1",
    urlpd_pkg::CharPct, "a", "F",
    urlpd_pkg::CharPct, "G",
    urlpd_pkg::CharPct, "7", "z",
    urlpd_pkg::CharPct, "3", urlpd_pkg::CharPct, "4", "2",
    urlpd_pkg::CharPct, urlpd_pkg::CharNul,
    urlpd_pkg::CharPct, "9", urlpd_pkg::CharNul
  };

  url_percent_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .last_of_run_o(last_of_run),
    .string_end_o (string_end)
  );

  url_percent_decoder_checker flow_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .last_of_run_i(last_of_run),
    .string_end_i (string_end),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(urlpd_pkg::CharZero + v);
    if ($urandom_range(0, 1) != 0) return 8'(urlpd_pkg::CharUpA + v - 10);
    return 8'(urlpd_pkg::CharLowA + v - 10);
  endfunction

  // Nonzero and never a hex digit; the percent sign is included.
  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h67, 8'hFF));
      1:       return 8'($urandom_range(8'h01, 8'h2F));
      2:       return 8'($urandom_range(8'h3A, 8'h40));
      default: return 8'($urandom_range(8'h47, 8'h60));
    endcase
  endfunction

  task automatic send_word(input logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_byte  <= b;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
  endtask

  // Hold off the sender until every pending word has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic send_string();
    int unsigned len;
    int unsigned kind;
    len     = $urandom_range(1, 12);
    tx_calm = ($urandom_range(0, 4) == 0);
    repeat (len) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_word(urlpd_pkg::CharPct);
        send_word(hex_char());
        send_word(hex_char());
      end else if (kind < 70) begin
        send_word(8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 80) begin
        send_word(8'($urandom_range(1, 255)));
      end else begin
        send_word(urlpd_pkg::CharPct);
        if ($urandom_range(0, 1) != 0) send_word(hex_char());
        send_word(($urandom_range(0, 5) == 0) ? urlpd_pkg::CharNul : non_hex_char());
      end
    end
    if ($urandom_range(0, 9) != 0) send_word(urlpd_pkg::CharNul);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_seq[i]) send_word(directed_seq[i]);
    drain_results();
    while (words_sent < DirectedWords + RandomWords) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 10)) send_word(8'($urandom_range(0, 255)));
      end else begin
        send_string();
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("url_percent_decoder verification clean");
    end else begin
      $display("url_percent_decoder verification failed");
    end
    $finish;
  end

  // Receiver: alternate quiet stretches with stretches of short and long stalls.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_calm      = ($urandom_range(0, 3) == 0);
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold != 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      rx_hold   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 29);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("url_percent_decoder verification failed");
    $finish;
  end

endmodule
